// ----- rtl/code128_symbol_encoder_macros.svh -----
// Assertion macros used by the encoder back end (c128_back).
`ifndef CODE128_SYMBOL_ENCODER_MACROS_SVH
`define CODE128_SYMBOL_ENCODER_MACROS_SVH

// Condition must hold at every sampled edge out of reset.
`define C128_ASSERT_ALWAYS(lbl, clk, rstn, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (cond)) else $error(msg);

// Antecedent implies consequent in the same cycle.
`define C128_ASSERT_IMPLIES(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) else $error(msg);

// Antecedent implies consequent in the next cycle.
`define C128_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) else $error(msg);

`endif

// ----- rtl/c128_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package c128_pkg;

    localparam int MAX_MESSAGE_CHARS = 80;
    localparam int CHAR_CNT_W        = 7;

    localparam int CHAR_W   = 8;
    localparam int DIGIT_W  = 4;
    localparam int SYM_W    = 7;
    localparam int BITS_W   = 13;
    localparam int MCNT_W   = 4;
    localparam int WEIGHT_W = 7;
    localparam int PROD_W   = SYM_W + WEIGHT_W;

    localparam logic [SYM_W-1:0] SYM_START_B = 7'd104;
    localparam logic [SYM_W-1:0] SYM_START_C = 7'd105;
    localparam logic [SYM_W-1:0] SYM_STOP    = 7'd106;
    localparam int               CHECK_MOD   = 103;
    localparam int               MOD_STEPS   = 7;
    localparam int               NUM_PATTERNS = 106;

    localparam logic [CHAR_W-1:0] CHAR_SPACE      = 8'd32;
    localparam logic [CHAR_W-1:0] CHAR_ZERO       = 8'd48;
    localparam logic [CHAR_W-1:0] CHAR_NINE       = 8'd57;
    localparam logic [CHAR_W-1:0] SET_C_MAX_CHAR  = 8'd102;
    localparam logic [CHAR_W-1:0] SET_B_MAX_CHAR  = 8'd134;

    localparam logic [MCNT_W-1:0] PATTERN_LEN = 4'd11;
    localparam logic [MCNT_W-1:0] STOP_LEN    = 4'd13;
    localparam logic [BITS_W-1:0] STOP_BITS   = 13'b1100011101011;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Result slots of one job, emitted lowest index first.
    localparam int NUM_SLOTS  = 6;
    localparam int SLOT_ERR   = 0;
    localparam int SLOT_START = 1;
    localparam int SLOT_FLUSH = 2;
    localparam int SLOT_DATA  = 3;
    localparam int SLOT_CHECK = 4;
    localparam int SLOT_STOP  = 5;

    typedef enum logic [1:0] {
        ERR_NONE     = 2'd0,
        ERR_OVERLONG = 2'd1,
        ERR_RANGE    = 2'd2
    } c128_err_t;

    typedef struct packed {
        logic [NUM_SLOTS-1:0] slots;
        logic                 set_c;
        logic [DIGIT_W-1:0]   flush_val;
        logic [SYM_W-1:0]     data_val;
        c128_err_t            err;
    } c128_job_t;

    localparam logic [10:0] PATTERN_TABLE [NUM_PATTERNS] = '{
        11'b11011001100, 11'b11001101100, 11'b11001100110, 11'b10010011000, 11'b10010001100,
        11'b10001001100, 11'b10011001000, 11'b10011000100, 11'b10001100100, 11'b11001001000,
        11'b11001000100, 11'b11000100100, 11'b10110011100, 11'b10011011100, 11'b10011001110,
        11'b10111001100, 11'b10011101100, 11'b10011100110, 11'b11001110010, 11'b11001011100,
        11'b11001001110, 11'b11011100100, 11'b11001110100, 11'b11101101110, 11'b11101001100,
        11'b11100101100, 11'b11100100110, 11'b11101100100, 11'b11100110100, 11'b11100110010,
        11'b11011011000, 11'b11011000110, 11'b11000110110, 11'b10100011000, 11'b10001011000,
        11'b10001000110, 11'b10110001000, 11'b10001101000, 11'b10001100010, 11'b11010001000,
        11'b11000101000, 11'b11000100010, 11'b10110111000, 11'b10110001110, 11'b10001101110,
        11'b10111011000, 11'b10111000110, 11'b10001110110, 11'b11101110110, 11'b11010001110,
        11'b11000101110, 11'b11011101000, 11'b11011100010, 11'b11011101110, 11'b11101011000,
        11'b11101000110, 11'b11100010110, 11'b11101101000, 11'b11101100010, 11'b11100011010,
        11'b11101111010, 11'b11001000010, 11'b11110001010, 11'b10100110000, 11'b10100001100,
        11'b10010110000, 11'b10010000110, 11'b10000101100, 11'b10000100110, 11'b10110010000,
        11'b10110000100, 11'b10011010000, 11'b10011000010, 11'b10000110100, 11'b10000110010,
        11'b11000010010, 11'b11001010000, 11'b11110111010, 11'b11000010100, 11'b10001111010,
        11'b10100111100, 11'b10010111100, 11'b10010011110, 11'b10111100100, 11'b10011110100,
        11'b10011110010, 11'b11110100100, 11'b11110010100, 11'b11110010010, 11'b11011011110,
        11'b11011110110, 11'b11110110110, 11'b10101111000, 11'b10100011110, 11'b10001011110,
        11'b10111101000, 11'b10111100010, 11'b11110101000, 11'b11110100010, 11'b10111011110,
        11'b10111101110, 11'b11101011110, 11'b11110101110, 11'b11010000100, 11'b11010010000,
        11'b11010011100
    };

    function automatic logic [BITS_W-1:0] c128_pattern(input logic [SYM_W-1:0] sym);
        logic [BITS_W-1:0] bits;
        bits = '0;
        if (sym == SYM_STOP) begin
            bits = STOP_BITS;
        end else if (int'(sym) < NUM_PATTERNS) begin
            bits = {2'b00, PATTERN_TABLE[sym]};
        end
        return bits;
    endfunction

    // Remainder by 103 through a fixed chain of compare and subtract steps.
    function automatic logic [SYM_W-1:0] c128_mod103(input logic [PROD_W-1:0] x);
        logic [PROD_W-1:0] r;
        r = x;
        for (int k = MOD_STEPS - 1; k >= 0; k--) begin
            if (r >= PROD_W'(CHECK_MOD << k)) begin
                r = r - PROD_W'(CHECK_MOD << k);
            end
        end
        return r[SYM_W-1:0];
    endfunction

endpackage

`default_nettype wire

// ----- rtl/c128_front.sv -----
`timescale 1ns / 1ps
`default_nettype none

module c128_front import c128_pkg::*; (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_wr_en,
    input  logic               cfg_wr_data,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [CHAR_W-1:0]  s_char_code,
    input  logic               s_end_of_message,
    input  logic               q_full,
    output logic               push,
    output c128_job_t          push_job
);

    logic                  code_set_reg;
    logic [CHAR_CNT_W-1:0] char_count_reg, char_count_next;
    logic [DIGIT_W-1:0]    held_digit_reg, held_digit_next;
    logic                  held_valid_reg, held_valid_next;
    logic                  started_reg, started_next;
    logic                  err_latched_reg, err_latched_next;

    logic                  accept;
    logic                  is_digit;
    logic                  range_bad;
    logic [DIGIT_W-1:0]    digit_val;
    c128_job_t             job;

    assign s_ready = !q_full;
    assign accept  = s_valid && s_ready;

    always_comb begin
        is_digit  = (s_char_code >= CHAR_ZERO) && (s_char_code <= CHAR_NINE);
        digit_val = DIGIT_W'(s_char_code - CHAR_ZERO);
        if (code_set_reg) begin
            range_bad = !is_digit && (s_char_code > SET_C_MAX_CHAR);
        end else begin
            range_bad = (s_char_code < CHAR_SPACE) || (s_char_code > SET_B_MAX_CHAR);
        end

        job              = '0;
        job.set_c        = code_set_reg;
        job.err          = ERR_NONE;
        char_count_next  = char_count_reg;
        held_digit_next  = held_digit_reg;
        held_valid_next  = held_valid_reg;
        started_next     = started_reg;
        err_latched_next = err_latched_reg;

        if (err_latched_reg) begin
            // swallow the rest of a failed message
            if (s_end_of_message) begin
                char_count_next  = '0;
                held_digit_next  = '0;
                held_valid_next  = 1'b0;
                started_next     = 1'b0;
                err_latched_next = 1'b0;
            end
        end else if ((int'(char_count_reg) >= MAX_MESSAGE_CHARS) || range_bad) begin
            job.slots[SLOT_ERR] = 1'b1;
            job.err = (int'(char_count_reg) >= MAX_MESSAGE_CHARS) ? ERR_OVERLONG : ERR_RANGE;
            if (s_end_of_message) begin
                char_count_next = '0;
                held_digit_next = '0;
                held_valid_next = 1'b0;
                started_next    = 1'b0;
            end else begin
                err_latched_next = 1'b1;
            end
        end else begin
            char_count_next = char_count_reg + 1'b1;
            job.slots[SLOT_START] = !started_reg;
            started_next = 1'b1;
            if (code_set_reg && is_digit) begin
                if (held_valid_reg) begin
                    job.slots[SLOT_DATA] = 1'b1;
                    job.data_val = SYM_W'({held_digit_reg, 3'b000})
                                 + SYM_W'({held_digit_reg, 1'b0})
                                 + SYM_W'(digit_val);
                    held_valid_next = 1'b0;
                    held_digit_next = '0;
                end else if (s_end_of_message) begin
                    job.slots[SLOT_DATA] = 1'b1;
                    job.data_val = SYM_W'(digit_val);
                end else begin
                    held_digit_next = digit_val;
                    held_valid_next = 1'b1;
                end
            end else begin
                if (held_valid_reg) begin
                    job.slots[SLOT_FLUSH] = 1'b1;
                    job.flush_val = held_digit_reg;
                    held_valid_next = 1'b0;
                    held_digit_next = '0;
                end
                job.slots[SLOT_DATA] = 1'b1;
                job.data_val = code_set_reg ? s_char_code[SYM_W-1:0]
                                            : SYM_W'(s_char_code - CHAR_SPACE);
            end
            if (s_end_of_message) begin
                job.slots[SLOT_CHECK] = 1'b1;
                job.slots[SLOT_STOP]  = 1'b1;
                char_count_next = '0;
                held_digit_next = '0;
                held_valid_next = 1'b0;
                started_next    = 1'b0;
            end
        end
    end

    assign push     = accept && (job.slots != '0);
    assign push_job = job;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            code_set_reg    <= 1'b0;
            char_count_reg  <= '0;
            held_digit_reg  <= '0;
            held_valid_reg  <= 1'b0;
            started_reg     <= 1'b0;
            err_latched_reg <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                code_set_reg <= cfg_wr_data;
            end
            if (accept) begin
                char_count_reg  <= char_count_next;
                held_digit_reg  <= held_digit_next;
                held_valid_reg  <= held_valid_next;
                started_reg     <= started_next;
                err_latched_reg <= err_latched_next;
            end
        end
    end

endmodule

`default_nettype wire

// ----- rtl/c128_queue.sv -----
`timescale 1ns / 1ps
`default_nettype none

module c128_queue import c128_pkg::*; (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      push,
    input  c128_job_t push_job,
    output logic      full,
    input  logic      pop,
    output logic      valid,
    output c128_job_t pop_job
);

    c128_job_t         entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg;
    logic              do_pop;

    assign full    = (int'(count_reg) == QUEUE_DEPTH);
    assign valid   = (count_reg != '0);
    assign pop_job = entry_reg[rd_ptr_reg];
    assign do_pop  = pop && valid;

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_job;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= (int'(wr_ptr_reg) == QUEUE_DEPTH - 1) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop) begin
                rd_ptr_reg <= (int'(rd_ptr_reg) == QUEUE_DEPTH - 1) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !do_pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (do_pop && !push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

// ----- rtl/c128_back.sv -----
`timescale 1ns / 1ps
`default_nettype none
`include "code128_symbol_encoder_macros.svh"

module c128_back import c128_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              q_valid,
    input  c128_job_t         q_job,
    output logic              q_pop,
    output logic              m_valid,
    input  logic              m_ready,
    output logic [SYM_W-1:0]  m_symbol_value,
    output logic [BITS_W-1:0] m_module_bits,
    output logic [MCNT_W-1:0] m_module_count,
    output logic [1:0]        m_error_code,
    output logic              m_final_symbol
);

    c128_job_t            job_reg;
    logic [NUM_SLOTS-1:0] mask_reg;

    logic [SYM_W-1:0]     acc_reg, acc_next;
    logic [WEIGHT_W-1:0]  weight_reg, weight_next;
    logic [PROD_W-1:0]    prod_reg, prod_next;

    logic                 out_valid_reg;
    logic [SYM_W-1:0]     out_sym_reg;
    logic [BITS_W-1:0]    out_bits_reg;
    logic [MCNT_W-1:0]    out_count_reg;
    c128_err_t            out_err_reg;
    logic                 out_final_reg;

    logic                 out_free;
    logic                 emit;
    logic [NUM_SLOTS-1:0] cur_slot;
    logic [NUM_SLOTS-1:0] mask_rest;
    logic [SYM_W-1:0]     check_val;
    logic [SYM_W-1:0]     sym_sel;

    assign out_free  = !out_valid_reg || m_ready;
    assign emit      = out_free && (mask_reg != '0);
    assign cur_slot  = mask_reg & (~mask_reg + 1'b1);
    assign mask_rest = mask_reg & ~cur_slot;
    assign q_pop     = q_valid && ((mask_reg == '0) || (emit && (mask_rest == '0)));
    assign check_val = c128_mod103(prod_reg + PROD_W'(acc_reg));

    always_comb begin
        sym_sel = '0;
        if (cur_slot[SLOT_START]) begin
            sym_sel = job_reg.set_c ? SYM_START_C : SYM_START_B;
        end else if (cur_slot[SLOT_FLUSH]) begin
            sym_sel = SYM_W'(job_reg.flush_val);
        end else if (cur_slot[SLOT_DATA]) begin
            sym_sel = job_reg.data_val;
        end else if (cur_slot[SLOT_CHECK]) begin
            sym_sel = check_val;
        end else if (cur_slot[SLOT_STOP]) begin
            sym_sel = SYM_STOP;
        end
    end

    // Checksum: product registered on emission, folded into the sum in the next cycle; stop or error clears it.
    always_comb begin
        acc_next    = check_val;
        weight_next = weight_reg;
        prod_next   = '0;
        if (emit) begin
            if (cur_slot[SLOT_STOP] || cur_slot[SLOT_ERR]) begin
                acc_next    = '0;
                weight_next = WEIGHT_W'(1);
            end else if (cur_slot[SLOT_START]) begin
                prod_next = sym_sel * weight_reg;
            end else if (cur_slot[SLOT_FLUSH] || cur_slot[SLOT_DATA]) begin
                prod_next   = sym_sel * weight_reg;
                weight_next = weight_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (q_pop) begin
            job_reg <= q_job;
        end
        if (emit) begin
            out_final_reg <= (mask_rest == '0);
            if (cur_slot[SLOT_ERR]) begin
                out_sym_reg   <= '0;
                out_bits_reg  <= '0;
                out_count_reg <= '0;
                out_err_reg   <= job_reg.err;
            end else begin
                out_sym_reg   <= sym_sel;
                out_bits_reg  <= c128_pattern(sym_sel);
                out_count_reg <= cur_slot[SLOT_STOP] ? STOP_LEN : PATTERN_LEN;
                out_err_reg   <= ERR_NONE;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mask_reg      <= '0;
            out_valid_reg <= 1'b0;
            acc_reg       <= '0;
            weight_reg    <= WEIGHT_W'(1);
            prod_reg      <= '0;
        end else begin
            if (q_pop) begin
                mask_reg <= q_job.slots;
            end else if (emit) begin
                mask_reg <= mask_rest;
            end
            if (emit) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
            acc_reg    <= acc_next;
            weight_reg <= weight_next;
            prod_reg   <= prod_next;
        end
    end

    assign m_valid        = out_valid_reg;
    assign m_symbol_value = out_sym_reg;
    assign m_module_bits  = out_bits_reg;
    assign m_module_count = out_count_reg;
    assign m_error_code   = out_err_reg;
    assign m_final_symbol = out_final_reg;

    `C128_ASSERT_IMPLIES(a_err_alone, aclk, aresetn, mask_reg[SLOT_ERR], mask_reg == NUM_SLOTS'(1 << SLOT_ERR), "error job carries other slots")
    `C128_ASSERT_ALWAYS(a_weight_nonzero, aclk, aresetn, weight_reg != '0, "check weight is zero")
    `C128_ASSERT_NEXT(a_stop_clears, aclk, aresetn, emit && cur_slot[SLOT_STOP], (acc_reg == '0) && (prod_reg == '0) && (weight_reg == WEIGHT_W'(1)), "checksum not cleared after stop")
    `C128_ASSERT_IMPLIES(a_pop_nonempty, aclk, aresetn, q_pop, q_job.slots != '0, "popped job has no results")

endmodule

`default_nettype wire

// ----- rtl/code128_symbol_encoder.sv -----
// Channel   | Ports                                        | Direction
// ----------+----------------------------------------------+----------
// config    | cfg_wr_en, cfg_wr_data                       | in
// character | s_valid, s_ready, s_char_code, s_end_of_message | in
// symbol    | m_valid, m_ready, m_symbol_value, m_module_bits,| out
//           | m_module_count, m_error_code, m_final_symbol |
//
// Characters are taken one a cycle while the 4-entry job queue has room.
// Each character yields 0 to 4 symbols; the back end sends one symbol a cycle
// from its output register while m_ready is high.
// First symbol of a character passes the job queue, the back end's job register and its output register.
// Reset is synchronous (aresetn low): clears message state, queue and output; code set is B.
// m_ready low holds the output beat; the queue then fills and s_ready drops.
`timescale 1ns / 1ps
`default_nettype none

module code128_symbol_encoder import c128_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              cfg_wr_en,
    input  logic              cfg_wr_data,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic [CHAR_W-1:0] s_char_code,
    input  logic              s_end_of_message,
    output logic              m_valid,
    input  logic              m_ready,
    output logic [SYM_W-1:0]  m_symbol_value,
    output logic [BITS_W-1:0] m_module_bits,
    output logic [MCNT_W-1:0] m_module_count,
    output logic [1:0]        m_error_code,
    output logic              m_final_symbol
);

    logic      push;
    c128_job_t push_job;
    logic      q_full;
    logic      q_pop;
    logic      q_valid;
    c128_job_t q_job;

    c128_front u_front (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_wr_en        (cfg_wr_en),
        .cfg_wr_data      (cfg_wr_data),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_char_code      (s_char_code),
        .s_end_of_message (s_end_of_message),
        .q_full           (q_full),
        .push             (push),
        .push_job         (push_job)
    );

    c128_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .push_job (push_job),
        .full     (q_full),
        .pop      (q_pop),
        .valid    (q_valid),
        .pop_job  (q_job)
    );

    c128_back u_back (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .q_valid        (q_valid),
        .q_job          (q_job),
        .q_pop          (q_pop),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_symbol_value (m_symbol_value),
        .m_module_bits  (m_module_bits),
        .m_module_count (m_module_count),
        .m_error_code   (m_error_code),
        .m_final_symbol (m_final_symbol)
    );

endmodule

`default_nettype wire
